// ===== rtl/dgcd_pkg.sv =====
// ----------------------------------------------------------------------------
// dgcd_pkg
// Constants that the cycle detector core uses.
// ----------------------------------------------------------------------------
package dgcd_pkg;
    localparam int MaxVertices = 1024;
    localparam int MaxEdges    = 4096;
    localparam int VW = $clog2(MaxVertices);   // vertex number width
    localparam int EW = $clog2(MaxEdges);      // edge index width
    localparam int PW = EW + 1;                // edge number plus one

    localparam logic [1:0] MARK_FREE = 2'd0;
    localparam logic [1:0] MARK_PATH = 2'd1;
    localparam logic [1:0] MARK_DONE = 2'd2;

    localparam logic CMD_ADD  = 1'b0;
    localparam logic CMD_EVAL = 1'b1;

    // byte address of vertex_count on the apb port
    localparam logic [1:0] ADDR_VERTEX_COUNT = 2'd0;
endpackage

// ===== rtl/directed_graph_cycle_detector_core.sv =====
// ----------------------------------------------------------------------------
// directed_graph_cycle_detector_core
// Edge loader and depth-first cycle search over memory-held adjacency lists.
// ----------------------------------------------------------------------------
// Input channel: an add item (command 0) stores one directed edge and gives no
// result; when the edge memory is full the edge is dropped and flagged in the
// edge_overflow of the next result. No item is taken while the list update
// runs in S_ADD. An evaluate item (command 1) walks the graph from vertices
// 0 .. vertex_count and delivers one result item (has_cycle, edge_overflow).
// The head, edge, mark and stack memories all have registered reads; the walk
// stops at the first cycle found. Once the result is in the output register
// the graph is cleared by a sweep over all MaxVertices entries of the head and
// mark memories; no item is taken during that sweep. After reset the same
// sweep runs before the first item is accepted.
// While the receiver stalls the result holds; adds are still taken, and a
// further evaluate finishes its walk but waits until the first result leaves.
// vertex_count is written over the APB port at address 0.
// ----------------------------------------------------------------------------
module directed_graph_cycle_detector_core
    import dgcd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_command,
    input  logic [9:0]  i_from_vertex,
    input  logic [9:0]  i_to_vertex,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_has_cycle,
    output logic        o_edge_overflow,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam logic [3:0] S_CLEAR = 4'd0, S_IDLE  = 4'd1, S_ADD   = 4'd2,
                           S_START = 4'd3, S_ROOT  = 4'd4, S_DONE  = 4'd5,
                           S_EDGE  = 4'd6, S_FETCH = 4'd7, S_DEST  = 4'd8,
                           S_POP   = 4'd9, S_OUT   = 4'd10;

    logic [PW-1:0] m_head [MaxVertices];
    logic [VW-1:0] m_tgt  [MaxEdges];
    logic [PW-1:0] m_link [MaxEdges];
    logic [1:0]    m_mark [MaxVertices];
    logic [VW+PW-1:0] m_stk [MaxVertices];

    logic [3:0]    r_state;
    logic [VW-1:0] r_vcount;
    logic [PW-1:0] r_loaded;
    logic          r_ovf;
    logic [VW-1:0] r_idx;     // clear sweep / start vertex
    logic [VW:0]   r_depth;
    logic [VW-1:0] r_cur;     // top vertex of the walk
    logic [PW-1:0] r_next;
    logic [VW-1:0] r_from, r_to;
    logic          r_found;
    logic          r_oval, r_ohc, r_oov;
    logic [PW-1:0] r_head_q, r_link_q;
    logic [VW-1:0] r_tgt_q;
    logic [1:0]    r_mark_q;
    logic [VW+PW-1:0] r_stk_q;

    logic acc_in, acc_out, out_free, cfg_wr, is_full, do_push;
    assign acc_in   = i_valid && !o_stall;
    assign acc_out  = r_oval && !i_stall;
    assign out_free = !r_oval || !i_stall;
    assign o_stall  = (r_state != S_IDLE);
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign pready   = 1'b1;
    assign prdata   = (paddr == ADDR_VERTEX_COUNT) ? 32'(r_vcount) : 32'd0;
    assign o_valid  = r_oval;
    assign o_has_cycle = r_ohc;
    assign o_edge_overflow = r_oov;

    assign is_full = (r_loaded == PW'(MaxEdges));
    assign do_push = (r_state == S_DEST) && (r_mark_q == MARK_FREE) &&
                     (r_depth != (VW+1)'(MaxVertices));

    // head and mark reads: start vertex or edge destination; else head reads the add source
    logic [VW-1:0] head_ra;
    logic [VW-1:0] mark_ra;
    always_comb begin
        if (r_state == S_START) begin
            head_ra = r_idx;
            mark_ra = r_idx;
        end else if (r_state == S_FETCH) begin
            head_ra = r_tgt_q;
            mark_ra = r_tgt_q;
        end else begin
            head_ra = i_from_vertex;
            mark_ra = r_tgt_q;
        end
    end

    always_ff @(posedge i_clk) begin
        r_head_q <= m_head[head_ra];
        if (r_state == S_ADD) m_head[r_from] <= r_loaded + PW'(1);
        else if (r_state == S_CLEAR) m_head[r_idx] <= '0;
    end

    always_ff @(posedge i_clk) begin
        r_mark_q <= m_mark[mark_ra];
        if (r_state == S_CLEAR) m_mark[r_idx] <= MARK_FREE;
        else if (r_state == S_ROOT && r_mark_q == MARK_FREE) m_mark[r_idx] <= MARK_PATH;
        else if (r_state == S_EDGE && r_next == '0) m_mark[r_cur] <= MARK_DONE;
        else if (do_push) m_mark[r_tgt_q] <= MARK_PATH;
    end

    // r_tgt_q still holds the destination in S_DEST, as r_next changes only at the end of S_FETCH
    logic [EW-1:0] eidx;
    assign eidx = EW'(r_next - PW'(1));
    always_ff @(posedge i_clk) begin
        r_tgt_q  <= m_tgt[eidx];
        r_link_q <= m_link[eidx];
        if (r_state == S_ADD) begin
            m_tgt[r_loaded[EW-1:0]]  <= r_to;
            m_link[r_loaded[EW-1:0]] <= r_head_q;
        end
    end

    // stack holds the frames below the top, top frame lives in r_cur/r_next
    logic [VW-1:0] stk_ra;
    assign stk_ra = VW'(r_depth - (VW+1)'(2));
    always_ff @(posedge i_clk) begin
        r_stk_q <= m_stk[stk_ra];
        if (do_push)
            m_stk[VW'(r_depth - (VW+1)'(1))] <= {r_cur, r_next};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR; r_vcount <= '0; r_loaded <= '0; r_ovf <= 1'b0;
            r_idx <= '0; r_depth <= '0; r_oval <= 1'b0; r_found <= 1'b0;
            r_cur <= '0; r_next <= '0; r_from <= '0; r_to <= '0;
            r_ohc <= 1'b0; r_oov <= 1'b0;
        end else begin
            if (cfg_wr && paddr == ADDR_VERTEX_COUNT) r_vcount <= pwdata[VW-1:0];
            if (r_state == S_OUT && out_free) r_oval <= 1'b1;
            else if (acc_out) r_oval <= 1'b0;
            unique case (r_state)
                S_CLEAR: begin
                    r_idx <= r_idx + VW'(1);
                    if (r_idx == VW'(MaxVertices - 1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (acc_in) begin
                        if (i_command == CMD_EVAL) begin
                            r_state <= S_START; r_idx <= '0; r_found <= 1'b0;
                            r_depth <= '0;
                        end else if (is_full) begin
                            r_ovf <= 1'b1;
                        end else begin
                            r_from <= i_from_vertex; r_to <= i_to_vertex;
                            r_state <= S_ADD;
                        end
                    end
                end
                // old head of the source list is in r_head_q now
                S_ADD: begin
                    r_loaded <= r_loaded + PW'(1);
                    r_state <= S_IDLE;
                end
                S_START: r_state <= S_ROOT;
                S_ROOT: begin
                    if (r_mark_q == MARK_FREE) begin
                        r_cur <= r_idx; r_next <= r_head_q;
                        r_depth <= (VW+1)'(1); r_state <= S_EDGE;
                    end else r_state <= S_DONE;
                end
                S_DONE: begin
                    if (r_idx == r_vcount) r_state <= S_OUT;
                    else begin
                        r_idx <= r_idx + VW'(1); r_state <= S_START;
                    end
                end
                S_EDGE: begin
                    if (r_next == '0) begin
                        r_depth <= r_depth - (VW+1)'(1);
                        r_state <= (r_depth == (VW+1)'(1)) ? S_DONE : S_POP;
                    end else r_state <= S_FETCH;
                end
                S_POP: begin
                    r_cur <= r_stk_q[VW+PW-1:PW]; r_next <= r_stk_q[PW-1:0];
                    r_state <= S_EDGE;
                end
                S_FETCH: begin
                    r_next <= r_link_q;
                    r_state <= S_DEST;
                end
                S_DEST: begin
                    if (r_mark_q == MARK_PATH) begin
                        r_found <= 1'b1; r_state <= S_OUT;
                    end else begin
                        if (do_push) begin
                            r_cur <= r_tgt_q; r_next <= r_head_q;
                            r_depth <= r_depth + (VW+1)'(1);
                        end
                        r_state <= S_EDGE;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_ohc <= r_found; r_oov <= r_ovf;
                        r_loaded <= '0; r_ovf <= 1'b0; r_depth <= '0;
                        r_idx <= '0; r_state <= S_CLEAR;
                    end
                end
                default: r_state <= S_CLEAR;
            endcase
        end
    end

    logic unused;
    assign unused = ^pwdata[31:VW];
endmodule

// ===== rtl/dgcd_checker.sv =====
// ----------------------------------------------------------------------------
// dgcd_checker
// Port-level checks on the cycle detector handshakes.
// ----------------------------------------------------------------------------
module dgcd_checker
(
    input logic i_clk,
    input logic i_rst_n,
    input logic o_stall,
    input logic o_valid,
    input logic i_stall,
    input logic o_has_cycle,
    input logic o_edge_overflow,
    input logic pready
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_has_cycle) && $stable(o_edge_overflow))
        else $error("hold");
    a_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$isunknown({o_valid, o_stall})) else $error("known");
    a_rdy: assert property (@(posedge i_clk) pready) else $error("pready");
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid && o_stall)
        else $error("rst");
endmodule

bind directed_graph_cycle_detector_core dgcd_checker u_chk (.*);
